### sv/assert_macros.svh
// Assertion macros used by json_string_escaper for its concurrent checks.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/jse_pkg.sv
// Shared types, codes and helpers for the JSON string escaper.
// No dependencies; used by jse_decode and json_string_escaper.
package jse_pkg;

  // Decoder phase codes (continuation bytes still expected and their ranges)
  localparam logic [3:0] PH_ACCEPT = 4'd0;  // between code points
  localparam logic [3:0] PH_LAST1  = 4'd1;  // one continuation left, 80..BF
  localparam logic [3:0] PH_TWO    = 4'd2;  // two left, 80..BF first
  localparam logic [3:0] PH_E0     = 4'd3;  // after E0: A0..BF first
  localparam logic [3:0] PH_ED     = 4'd4;  // after ED: 80..9F first
  localparam logic [3:0] PH_F0     = 4'd5;  // after F0: 90..BF first
  localparam logic [3:0] PH_THREE  = 4'd6;  // after F1..F3: 80..BF first
  localparam logic [3:0] PH_F4     = 4'd7;  // after F4: 80..8F first

  // Kinds of result run produced by one request
  localparam logic [2:0] RUN_CHAR = 3'd0;  // one plain character
  localparam logic [2:0] RUN_ESC  = 3'd1;  // backslash then one character
  localparam logic [2:0] RUN_UHEX = 3'd2;  // \uXXXX
  localparam logic [2:0] RUN_PAIR = 3'd3;  // \uXXXX\uXXXX surrogate pair
  localparam logic [2:0] RUN_ERR  = 3'd4;  // marker with decode error
  localparam logic [2:0] RUN_END  = 3'd5;  // marker closing a discarded string

  // ASCII characters used by the escapes
  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_QUOTE  = 7'h22;
  localparam logic [6:0] CH_U      = 7'h75;
  localparam logic [6:0] CH_B      = 7'h62;
  localparam logic [6:0] CH_T      = 7'h74;
  localparam logic [6:0] CH_N      = 7'h6E;
  localparam logic [6:0] CH_F      = 7'h66;
  localparam logic [6:0] CH_R      = 7'h72;

  // Last result index for each run length
  localparam logic [3:0] LAST_ONE  = 4'd0;
  localparam logic [3:0] LAST_TWO  = 4'd1;
  localparam logic [3:0] LAST_UHEX = 4'd5;
  localparam logic [3:0] LAST_PAIR = 4'd11;
  localparam logic [3:0] PAIR_HALF = 4'd6;   // first index of the low surrogate

  typedef struct packed {
    logic [3:0]  phase;
    logic [20:0] partial;
    logic        discarding;
  } dec_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  ch;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [3:0]  last_idx;
    logic        end_flag;
  } run_t;

  // Lowercase hex digit for one nibble
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] r;
    if (nib < 4'd10) r = 7'h30 + {3'b000, nib};
    else             r = 7'h57 + {3'b000, nib};
    return r;
  endfunction

endpackage

### sv/jse_decode.sv
// UTF-8 decode step and escape classification for one input byte.
// Depends on jse_pkg; purely combinational, instantiated by json_string_escaper.
module jse_decode (
  input  logic [7:0]         in_byte,
  input  logic               string_end,
  input  jse_pkg::dec_state_t state,
  output jse_pkg::dec_state_t state_next,
  output logic               has_run,
  output jse_pkg::run_t      run
);
  import jse_pkg::*;

  logic        bad;
  logic        done;
  logic [3:0]  ph;
  logic [20:0] pc;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [3:0]  nxt;
  logic [19:0] sup;
  run_t        esc;

  // Advance the strict UTF-8 decoder by one byte
  always_comb begin
    bad  = 1'b0;
    done = 1'b0;
    ph   = state.phase;
    pc   = state.partial;
    lo   = 8'h80;
    hi   = 8'hBF;
    nxt  = PH_ACCEPT;
    if (state.phase == PH_ACCEPT || state.phase[3]) begin
      if (!in_byte[7]) begin
        pc   = {13'd0, in_byte};
        done = 1'b1;
      end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
        ph = PH_LAST1;  pc = {16'd0, in_byte[4:0]};
      end else if (in_byte == 8'hE0) begin
        ph = PH_E0;     pc = {17'd0, in_byte[3:0]};
      end else if (in_byte == 8'hED) begin
        ph = PH_ED;     pc = {17'd0, in_byte[3:0]};
      end else if (in_byte >= 8'hE1 && in_byte <= 8'hEF) begin
        ph = PH_TWO;    pc = {17'd0, in_byte[3:0]};
      end else if (in_byte == 8'hF0) begin
        ph = PH_F0;     pc = {18'd0, in_byte[2:0]};
      end else if (in_byte >= 8'hF1 && in_byte <= 8'hF3) begin
        ph = PH_THREE;  pc = {18'd0, in_byte[2:0]};
      end else if (in_byte == 8'hF4) begin
        ph = PH_F4;     pc = {18'd0, in_byte[2:0]};
      end else begin
        bad = 1'b1;
      end
    end else begin
      if (state.phase == PH_E0)      lo = 8'hA0;
      else if (state.phase == PH_ED) hi = 8'h9F;
      else if (state.phase == PH_F0) lo = 8'h90;
      else if (state.phase == PH_F4) hi = 8'h8F;
      if (state.phase == PH_LAST1)    nxt = PH_ACCEPT;
      else if (state.phase <= PH_ED)  nxt = PH_LAST1;
      else                            nxt = PH_TWO;
      if (in_byte < lo || in_byte > hi) begin
        bad = 1'b1;
      end else begin
        pc   = {state.partial[14:0], in_byte[5:0]};
        ph   = nxt;
        done = (nxt == PH_ACCEPT);
      end
    end
  end

  // Classify the finished code point into an escape run
  assign sup = pc[19:0] - 20'h10000;

  always_comb begin
    esc          = '0;
    esc.kind     = RUN_UHEX;
    esc.w0       = pc[15:0];
    esc.last_idx = LAST_UHEX;
    if (pc >= 21'h20 && pc <= 21'h7E) begin
      esc.ch = pc[6:0];
      if (pc[6:0] == CH_QUOTE || pc[6:0] == CH_BSLASH) begin
        esc.kind = RUN_ESC;  esc.last_idx = LAST_TWO;
      end else begin
        esc.kind = RUN_CHAR; esc.last_idx = LAST_ONE;
      end
    end else if (pc == 21'h08 || pc == 21'h09 || pc == 21'h0A ||
                 pc == 21'h0C || pc == 21'h0D) begin
      esc.kind     = RUN_ESC;
      esc.last_idx = LAST_TWO;
      case (pc[3:0])
        4'h8:    esc.ch = CH_B;
        4'h9:    esc.ch = CH_T;
        4'hA:    esc.ch = CH_N;
        4'hC:    esc.ch = CH_F;
        default: esc.ch = CH_R;
      endcase
    end else if (pc > 21'hFFFF) begin
      esc.kind     = RUN_PAIR;
      esc.last_idx = LAST_PAIR;
      esc.w0       = 16'hD800 | {6'd0, sup[19:10]};
      esc.w1       = 16'hDC00 | {6'd0, sup[9:0]};
    end
  end

  // Pick the run and the next decoder state
  always_comb begin
    state_next   = state;
    has_run      = 1'b0;
    run          = esc;
    run.end_flag = string_end;
    if (state.discarding) begin
      if (string_end) begin
        has_run       = 1'b1;
        run           = '0;
        run.kind      = RUN_END;
        run.last_idx  = LAST_ONE;
        run.end_flag  = 1'b1;
        state_next    = '0;
      end
    end else begin
      state_next.phase   = ph;
      state_next.partial = pc;
      if (bad) begin
        has_run                 = 1'b1;
        run                     = '0;
        run.kind                = RUN_ERR;
        run.last_idx            = LAST_ONE;
        run.end_flag            = string_end;
        state_next.phase        = PH_ACCEPT;
        state_next.partial      = '0;
        state_next.discarding   = !string_end;
      end else if (done) begin
        has_run            = 1'b1;
        state_next.phase   = PH_ACCEPT;
        state_next.partial = '0;
      end else if (string_end) begin
        has_run      = 1'b1;
        run          = '0;
        run.kind     = RUN_ERR;
        run.last_idx = LAST_ONE;
        run.end_flag = 1'b1;
      end
      if (string_end) state_next = '0;
    end
  end

endmodule

### sv/json_string_escaper.sv
// JSON string escaper: UTF-8 bytes in, JSON-escaped ASCII characters out.
// Depends on jse_pkg, jse_decode and assert_macros.svh.
//
// Each request carries one raw UTF-8 byte and a string_end flag on the final
// byte of a string. A strict UTF-8 decoder (no overlong forms, no surrogates,
// nothing above U+10FFFF) runs in the same cycle as the request is accepted
// and updates its phase and partial code point at once. A byte that completes
// a code point loads a run register with a compact description of its escape
// (plain character, two-character escape, \uXXXX, or a surrogate pair as two
// \uXXXX groups); a run counter then walks that description and presents one
// character per cycle while out_ready is high. An invalid byte yields one
// marker result with decode_error set, and the rest of the string is dropped
// until string_end, which yields a marker result with end_mark. A string that
// ends inside a multi-byte sequence yields one error marker with end_mark.
// Bytes in the middle of a sequence yield no results. last_of_run flags the
// final result caused by a byte; end_mark flags it too when that byte ended
// the string. Rate: a request whose run is one result, or none, is taken every
// cycle while out_ready is high; a request whose run is n results (1, 2, 6 or
// 12) holds the run register until all of them are taken, and the next request
// is taken in the same cycle that the last result of the current run is taken.
// The run register is the only buffer between the two channels.
`include "assert_macros.svh"

module json_string_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       char_valid,
  output logic       last_of_run,
  output logic       end_mark,
  output logic       decode_error
);
  import jse_pkg::*;

  dec_state_t state;
  dec_state_t state_next;
  logic       has_run;
  run_t       run_new;

  run_t       run;
  logic       run_valid;
  logic [3:0] idx;

  logic       is_last;
  logic       in_take;
  logic       out_take;
  logic [3:0] pos;
  logic [15:0] word;
  logic [3:0] nib;

  // Decode the byte on the input channel against the current decoder state
  jse_decode u_decode (
    .in_byte    (in_byte),
    .string_end (string_end),
    .state      (state),
    .state_next (state_next),
    .has_run    (has_run),
    .run        (run_new)
  );

  assign is_last  = (idx == run.last_idx);
  assign in_ready = !run_valid || (out_ready && is_last);
  assign in_take  = in_valid && in_ready;
  assign out_take = run_valid && out_ready;

  // Hold decoder state; advance it only when a request is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Run register: load on accept, step through results as they are taken
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (in_take) begin
      run_valid <= has_run;
      idx       <= '0;
    end else if (out_take) begin
      if (is_last) begin
        run_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && has_run) run <= run_new;
  end

  // Select the character at the current run position
  assign pos  = (idx >= PAIR_HALF) ? (idx - PAIR_HALF) : idx;
  assign word = (idx >= PAIR_HALF) ? run.w1 : run.w0;

  always_comb begin
    case (pos)
      4'd2:    nib = word[15:12];
      4'd3:    nib = word[11:8];
      4'd4:    nib = word[7:4];
      default: nib = word[3:0];
    endcase
  end

  always_comb begin
    out_char     = '0;
    char_valid   = 1'b1;
    decode_error = 1'b0;
    unique case (run.kind)
      RUN_CHAR: out_char = run.ch;
      RUN_ESC:  out_char = (idx == '0) ? CH_BSLASH : run.ch;
      RUN_UHEX, RUN_PAIR: begin
        if (pos == 4'd0)      out_char = CH_BSLASH;
        else if (pos == 4'd1) out_char = CH_U;
        else                  out_char = hex_char(nib);
      end
      RUN_ERR: begin
        char_valid   = 1'b0;
        decode_error = 1'b1;
      end
      default: char_valid = 1'b0;
    endcase
  end

  assign out_valid   = run_valid;
  assign last_of_run = is_last;
  assign end_mark    = is_last && run.end_flag;

  // Drop no results: a new request never lands on a run still in progress
  `ASSERT_IMPL(a_no_overrun, run_valid && !is_last, !in_ready, "request accepted mid-run")
  // Run position stays within the run
  `ASSERT_IMPL(a_idx_range, run_valid, idx <= run.last_idx, "run index past end of run")
  // Marker results stand alone
  `ASSERT_IMPL(a_marker_single, out_valid && !char_valid, last_of_run, "marker not last of run")
  // The end of a string returns the decoder to its idle state
  `ASSERT_NEXT(a_end_clears, in_take && string_end, state == '0, "state not cleared at end")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for json_string_escaper: table-driven and random UTF-8 strings.
// Depends on jse_pkg and the json_string_escaper RTL; the escape predictor lives here.

module testbench;
  import jse_pkg::*;

  localparam int RANDOM_ITEMS   = 305;   // directed table adds 25 more
  localparam int DIRECTED_ROWS  = 25;
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no accepted request or result
  localparam int DRAIN_CYCLES   = 30;

  // One escaped character (or marker) leaving the block.
  typedef struct packed {
    logic [6:0] ch;
    logic       is_char;
    logic       run_last;
    logic       str_end;
    logic       err;
  } esc_result_t;

  // One row of the directed table; gold is used only where has_gold is set.
  typedef struct packed {
    logic [7:0]  b;
    logic        e;
    logic        has_gold;
    esc_result_t gold;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       string_end;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_char;
  logic       char_valid;
  logic       last_of_run;
  logic       end_mark;
  logic       decode_error;

  // Sideband that travels with each request: a typed-in result replaces the prediction.
  logic        use_golden;
  esc_result_t golden_res;

  json_string_escaper u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .string_end   (string_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .char_valid   (char_valid),
    .last_of_run  (last_of_run),
    .end_mark     (end_mark),
    .decode_error (decode_error)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Escape predictor: its own copy of the UTF-8 decoder state.
  // ---------------------------------------------------------------------------
  logic [3:0]  dec_phase;
  logic [20:0] dec_partial;
  logic        dec_discard;

  esc_result_t run_chars[$];       // results of the request being predicted
  esc_result_t expected_chars[$];  // results still owed by the block
  string       hex_digits = "0123456789abcdef";

  int mismatches = 0;
  int quiet_cycles = 0;
  bit send_calm;
  bit recv_calm;

  logic [7:0] string_bytes[$];     // bytes of the string being built

  function automatic void add_char(input logic [6:0] c, input logic is_char,
                                   input logic err);
    esc_result_t r;
    r.ch       = c;
    r.is_char  = is_char;
    r.run_last = 1'b0;
    r.str_end  = 1'b0;
    r.err      = err;
    run_chars.push_back(r);
  endfunction

  // Append \uXXXX with lowercase hex digits.
  function automatic void add_uhex(input logic [15:0] v);
    int k;
    add_char(CH_BSLASH, 1'b1, 1'b0);
    add_char(CH_U, 1'b1, 1'b0);
    for (k = 3; k >= 0; k--)
      add_char(7'(hex_digits[(v >> (4 * k)) & 16'hF]), 1'b1, 1'b0);
  endfunction

  function automatic void escape_codepoint(input logic [20:0] c);
    logic [6:0]  short_ch;
    logic [20:0] v;
    short_ch = 7'h00;
    if (c < 21'h20) begin
      case (c[4:0])
        5'h08: short_ch = CH_B;
        5'h09: short_ch = CH_T;
        5'h0A: short_ch = CH_N;
        5'h0C: short_ch = CH_F;
        5'h0D: short_ch = CH_R;
        default: short_ch = 7'h00;
      endcase
    end
    if (c >= 21'h20 && c <= 21'h7E) begin
      if (c[6:0] == CH_QUOTE || c[6:0] == CH_BSLASH)
        add_char(CH_BSLASH, 1'b1, 1'b0);
      add_char(c[6:0], 1'b1, 1'b0);
    end else if (short_ch != 7'h00) begin
      add_char(CH_BSLASH, 1'b1, 1'b0);
      add_char(short_ch, 1'b1, 1'b0);
    end else if (c <= 21'hFFFF) begin
      add_uhex(c[15:0]);
    end else begin
      // Split into a high/low surrogate pair.
      v = c - 21'h10000;
      add_uhex(16'hD800 | {6'b0, v[19:10]});
      add_uhex(16'hDC00 | {6'b0, v[9:0]});
    end
  endfunction

  // Advance the decoder by one byte and leave its results in run_chars.
  function automatic void predict_escape(input logic [7:0] b, input logic e);
    logic       bad;
    logic       done;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [3:0] ph;
    logic [3:0] nxt;
    esc_result_t tail;
    bad = 1'b0;
    done = 1'b0;
    run_chars.delete();
    ph = dec_phase;
    if (dec_discard) begin
      // Drop everything up to the end of the string; the end byte closes it.
      if (e) begin
        add_char(7'h00, 1'b0, 1'b0);
        dec_phase = PH_ACCEPT;
        dec_partial = '0;
        dec_discard = 1'b0;
      end
    end else begin
      if (ph == PH_ACCEPT || ph > PH_F4) begin
        // Lead byte: pick the continuation count and first-byte range.
        if (b < 8'h80) begin
          dec_partial = {13'b0, b};
          done = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          ph = PH_LAST1;
          dec_partial = {16'b0, b[4:0]};
        end else if (b == 8'hE0) begin
          ph = PH_E0;
          dec_partial = {17'b0, b[3:0]};
        end else if (b == 8'hED) begin
          ph = PH_ED;
          dec_partial = {17'b0, b[3:0]};
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
          ph = PH_TWO;
          dec_partial = {17'b0, b[3:0]};
        end else if (b == 8'hF0) begin
          ph = PH_F0;
          dec_partial = {18'b0, b[2:0]};
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
          ph = PH_THREE;
          dec_partial = {18'b0, b[2:0]};
        end else if (b == 8'hF4) begin
          ph = PH_F4;
          dec_partial = {18'b0, b[2:0]};
        end else begin
          bad = 1'b1;
        end
      end else begin
        // Continuation byte: narrowed range right after E0, ED, F0 and F4.
        lo = 8'h80;
        hi = 8'hBF;
        case (ph)
          PH_E0:   lo = 8'hA0;
          PH_ED:   hi = 8'h9F;
          PH_F0:   lo = 8'h90;
          PH_F4:   hi = 8'h8F;
          default: lo = 8'h80;
        endcase
        if (ph == PH_LAST1)   nxt = PH_ACCEPT;
        else if (ph <= PH_ED) nxt = PH_LAST1;
        else                  nxt = PH_TWO;
        if (b < lo || b > hi) begin
          bad = 1'b1;
        end else begin
          dec_partial = {dec_partial[14:0], b[5:0]};
          ph = nxt;
          done = (nxt == PH_ACCEPT);
        end
      end

      if (bad) begin
        add_char(7'h00, 1'b0, 1'b1);
        ph = PH_ACCEPT;
        dec_partial = '0;
        dec_discard = !e;
      end else if (done) begin
        escape_codepoint(dec_partial);
        dec_partial = '0;
        ph = PH_ACCEPT;
      end else if (e) begin
        // String ended inside a multi-byte sequence.
        add_char(7'h00, 1'b0, 1'b1);
      end
      dec_phase = ph;
      if (e) begin
        dec_phase = PH_ACCEPT;
        dec_partial = '0;
        dec_discard = 1'b0;
      end
    end
    if (run_chars.size() > 0) begin
      tail = run_chars.pop_back();
      tail.run_last = 1'b1;
      tail.str_end = e;
      run_chars.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted result.
  // Both sides are sampled at the rising edge, before the edge's updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    esc_result_t got;
    esc_result_t want;
    if (rst) begin
      dec_phase = PH_ACCEPT;
      dec_partial = '0;
      dec_discard = 1'b0;
      quiet_cycles <= 0;
    end else begin
      // Queue the prediction first so a same-edge result still finds its entry.
      if (in_valid && in_ready) begin
        predict_escape(in_byte, string_end);
        if (use_golden)
          expected_chars.push_back(golden_res);
        else
          foreach (run_chars[k]) expected_chars.push_back(run_chars[k]);
      end
      if (out_valid && out_ready) begin
        got = {out_char, char_valid, last_of_run, end_mark, decode_error};
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result ch=%h char=%b last=%b end=%b err=%b",
                   $time, got.ch, got.is_char, got.run_last, got.str_end, got.err);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) begin
            $display("%0t: expected ch=%h char=%b last=%b end=%b err=%b, got ch=%h char=%b last=%b end=%b err=%b",
                     $time, want.ch, want.is_char, want.run_last, want.str_end, want.err,
                     got.ch, got.is_char, got.run_last, got.str_end, got.err);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Drive one request and hold it until the block takes it. Valid stays high
  // across back-to-back requests; only the payload moves.
  task automatic send_request(input logic [7:0] b, input logic e,
                              input logic has_gold, input esc_result_t gold);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    string_end <= e;
    use_golden <= has_gold;
    golden_res <= gold;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic void append_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      string_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      string_bytes.push_back({3'b110, cp[10:6]});
      string_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      string_bytes.push_back({4'b1110, cp[15:12]});
      string_bytes.push_back({2'b10, cp[11:6]});
      string_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      // Above U+1FFFFF cannot occur; above U+10FFFF yields F4 90..BF or F5..F7 leads.
      string_bytes.push_back({5'b11110, cp[20:18]});
      string_bytes.push_back({2'b10, cp[17:12]});
      string_bytes.push_back({2'b10, cp[11:6]});
      string_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [20:0] pick_codepoint();
    logic [20:0] cp;
    case ($urandom_range(0, 15))
      3:  cp = ($urandom_range(0, 3) == 0) ? 21'h7F : 21'($urandom_range(0, 31));
      4:  cp = $urandom_range(0, 1) ? {14'b0, CH_QUOTE} : {14'b0, CH_BSLASH};
      5:  cp = 21'($urandom_range(21'h80, 21'h7FF));
      6: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
      end
      7:  cp = 21'($urandom_range(21'hD000, 21'hD7FF));    // ED lead, top of its range
      8:  cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      9: begin
        case ($urandom_range(0, 8))
          0:       cp = 21'h7F;
          1:       cp = 21'h80;
          2:       cp = 21'h7FF;
          3:       cp = 21'h800;
          4:       cp = 21'hD7FF;
          5:       cp = 21'hE000;
          6:       cp = 21'hFFFF;
          7:       cp = 21'h10000;
          default: cp = 21'h10FFFF;
        endcase
      end
      10: cp = 21'($urandom_range(21'h100000, 21'h10FFFF)); // F4 lead
      11: cp = $urandom_range(0, 1) ? 21'($urandom_range(21'hD800, 21'hDFFF))
                                    : 21'($urandom_range(21'h110000, 21'h1FFFFF));
      default: cp = 21'($urandom_range(21'h20, 21'h7E));
    endcase
    return cp;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall a random number of cycles before each result, with
  // stretches of full-rate acceptance.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    recv_calm = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: a run that stops moving is a failure.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [0:DIRECTED_ROWS-1];

  initial begin : main_seq
    int i;
    int sent;
    int n;
    int idx;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    string_end = 1'b0;
    use_golden = 1'b0;
    golden_res = '0;
    send_calm = 1'b0;

    // Directed table: byte, end, typed-in flag, {ch, char, last, end, err}.
    directed_rows[0]  = {8'h41, 1'b0, 1'b1, 7'h41, 1'b1, 1'b1, 1'b0, 1'b0}; // plain 'A'
    directed_rows[1]  = {8'h00, 1'b0, 1'b0, 11'h0};                          // NUL -> \u0000
    directed_rows[2]  = {8'h7F, 1'b0, 1'b0, 11'h0};                          // DEL -> \u007f
    directed_rows[3]  = {8'h22, 1'b0, 1'b0, 11'h0};                          // quote
    directed_rows[4]  = {8'h5C, 1'b0, 1'b0, 11'h0};                          // backslash
    directed_rows[5]  = {8'h08, 1'b0, 1'b0, 11'h0};                          // \b
    directed_rows[6]  = {8'h09, 1'b0, 1'b0, 11'h0};                          // \t
    directed_rows[7]  = {8'h0A, 1'b0, 1'b0, 11'h0};                          // \n
    directed_rows[8]  = {8'h0C, 1'b0, 1'b0, 11'h0};                          // \f
    directed_rows[9]  = {8'h0D, 1'b0, 1'b0, 11'h0};                          // \r
    directed_rows[10] = {8'h1F, 1'b0, 1'b0, 11'h0};                          // other control
    directed_rows[11] = {8'h7E, 1'b1, 1'b1, 7'h7E, 1'b1, 1'b1, 1'b1, 1'b0}; // top printable, end
    directed_rows[12] = {8'hC2, 1'b0, 1'b1, 11'h0};                          // mid-sequence: nothing
    directed_rows[13] = {8'h80, 1'b0, 1'b0, 11'h0};                          // U+0080
    directed_rows[14] = {8'hE0, 1'b0, 1'b1, 11'h0};                          // mid-sequence: nothing
    directed_rows[15] = {8'h9F, 1'b0, 1'b1, 7'h00, 1'b0, 1'b1, 1'b0, 1'b1}; // overlong after E0
    directed_rows[16] = {8'hAB, 1'b0, 1'b1, 11'h0};                          // discarded
    directed_rows[17] = {8'hFF, 1'b1, 1'b1, 7'h00, 1'b0, 1'b1, 1'b1, 1'b0}; // end while discarding
    directed_rows[18] = {8'hF4, 1'b0, 1'b0, 11'h0};
    directed_rows[19] = {8'h8F, 1'b0, 1'b0, 11'h0};
    directed_rows[20] = {8'hBF, 1'b0, 1'b0, 11'h0};
    directed_rows[21] = {8'hBF, 1'b1, 1'b0, 11'h0};                          // U+10FFFF, pair, end
    directed_rows[22] = {8'hF0, 1'b0, 1'b0, 11'h0};
    directed_rows[23] = {8'h90, 1'b1, 1'b1, 7'h00, 1'b0, 1'b1, 1'b1, 1'b1}; // truncated at end
    directed_rows[24] = {8'hFF, 1'b1, 1'b1, 7'h00, 1'b0, 1'b1, 1'b1, 1'b1}; // bad byte on end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Rows flagged as typed-in but without a result (mid-sequence, discarded)
    // must not push anything: hand them to the predictor instead.
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].has_gold && !directed_rows[i].gold.run_last)
        directed_rows[i].has_gold = 1'b0;
      send_request(directed_rows[i].b, directed_rows[i].e,
                   directed_rows[i].has_gold, directed_rows[i].gold);
    end

    // Random strings: mostly well-formed UTF-8 with random content, some
    // with a corrupted byte or a truncated tail, and some pure byte noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      string_bytes.delete();
      send_calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) string_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) append_utf8(pick_codepoint());
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            idx = $urandom_range(0, string_bytes.size() - 1);
            string_bytes[idx] = 8'($urandom_range(0, 255));
          end else if (string_bytes.size() > 1) begin
            void'(string_bytes.pop_back());
          end
        end
      end
      for (i = 0; i < string_bytes.size(); i++) begin
        send_request(string_bytes[i], i == string_bytes.size() - 1, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain: let the monitor queue the last request, wait for every owed
    // result, then watch for strays.
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/jse_pkg.sv
sv/jse_decode.sv
sv/json_string_escaper.sv
dv/testbench.sv
